[src/utf16_to_utf8_with_dedupe_macros.svh]
// Assertion macros used by the transcoder top level.
`ifndef UTF16_TO_UTF8_WITH_DEDUPE_MACROS_SVH
`define UTF16_TO_UTF8_WITH_DEDUPE_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define U2U_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define U2U_ASSERT_SAME(label, clk, rst, ante, cons)
`define U2U_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[src/u2u_pkg.sv]
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
`timescale 1ns / 1ps
`default_nettype none
package u2u_pkg;

   // Depth of the job queue between the front and the back.
   localparam int JOB_QUEUE_DEPTH = 2;

   // Reset value of the repeat window in milliseconds.
   localparam logic [15:0] WINDOW_RESET = 16'd60;

   // Surrogate ranges and the replacement character.
   localparam logic [15:0] HIGH_FIRST  = 16'hD800;
   localparam logic [15:0] HIGH_LAST   = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST   = 16'hDC00;
   localparam logic [15:0] LOW_LAST    = 16'hDFFF;
   localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] PLANE_BASE  = 21'h010000;

   // One unit of work for the back: an optional replacement character
   // followed by an optional code point.
   typedef struct packed {
      logic        has_fffd;
      logic        has_cp;
      logic [20:0] cp;
   } job_type;

   // Queue occupancy as seen by the front and the back.
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Back-side events.
   typedef struct packed {
      logic job_done;
   } back_status_type;

endpackage
`default_nettype wire

[src/u2u_front.sv]
// Front part: repeat suppression, surrogate pairing and job building.
`timescale 1ns / 1ps
`default_nettype none
module u2u_front
   import u2u_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [15:0]      code_unit,
   input  wire logic [31:0]      time_ms,
   input  wire logic [15:0]      window_ms,
   input  wire queue_status_type q_status,
   output logic                  full,
   output logic                  q_push,
   output job_type               q_job
);

   logic [15:0] held_high_ff, held_high_in;
   logic [15:0] prev_unit_ff, prev_unit_in;
   logic [31:0] prev_time_ff, prev_time_in;

   logic        accept;
   logic [31:0] elapsed;
   logic        drop;
   logic        unit_high;
   logic        unit_low;
   logic        held_active;

   assign full    = q_status.full;
   assign accept  = push && !q_status.full;
   assign elapsed = time_ms - prev_time_ff;
   assign drop    = (code_unit == prev_unit_ff) && (elapsed < {16'd0, window_ms});

   assign unit_high   = (code_unit >= HIGH_FIRST) && (code_unit <= HIGH_LAST);
   assign unit_low    = (code_unit >= LOW_FIRST) && (code_unit <= LOW_LAST);
   assign held_active = (held_high_ff != 16'd0);

   // Classify the word and decide what the back must emit.
   always_comb begin
      held_high_in = held_high_ff;
      prev_unit_in = prev_unit_ff;
      prev_time_in = prev_time_ff;
      q_job        = '0;
      if (accept && !drop) begin
         prev_unit_in = code_unit;
         prev_time_in = time_ms;
         held_high_in = 16'd0;
         if (held_active && unit_low) begin
            // Complete surrogate pair.
            q_job.has_cp = 1'b1;
            q_job.cp     = PLANE_BASE + {1'b0, held_high_ff[9:0], code_unit[9:0]};
         end else begin
            // An orphan high surrogate becomes a replacement character.
            q_job.has_fffd = held_active;
            if (unit_high) begin
               held_high_in = code_unit;
            end else if (unit_low) begin
               q_job.has_cp = 1'b1;
               q_job.cp     = REPLACEMENT;
            end else begin
               q_job.has_cp = 1'b1;
               q_job.cp     = {5'd0, code_unit};
            end
         end
      end
   end

   assign q_push = accept && !drop && (q_job.has_fffd || q_job.has_cp);

   // Transcoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_high_ff <= 16'd0;
         prev_unit_ff <= 16'd0;
         prev_time_ff <= 32'd0;
      end else begin
         held_high_ff <= held_high_in;
         prev_unit_ff <= prev_unit_in;
         prev_time_ff <= prev_time_in;
      end
   end

endmodule
`default_nettype wire

[src/u2u_queue.sv]
// Short job queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module u2u_queue
   import u2u_pkg::*;
#(
   parameter int DEPTH = JOB_QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire job_type     push_job,
   input  wire logic        pop,
   output job_type          head_job,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

[src/u2u_back.sv]
// Back part: serialises each job into UTF-8 bytes behind an output register.
`timescale 1ns / 1ps
`default_nettype none
module u2u_back
   import u2u_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire job_type          job,
   input  wire queue_status_type q_status,
   output logic                  q_pop,
   output back_status_type       b_status,
   input  wire logic             pop,
   output logic                  empty,
   output logic [7:0]            out_byte,
   output logic                  last_byte
);

   logic [2:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       valid_ff, valid_in;

   logic       advance;
   logic       in_fffd;
   logic [2:0] cp_idx;
   logic [2:0] cp_len;
   logic [7:0] cp_byte;
   logic [7:0] fffd_byte;

   assign advance = !q_status.empty && (!valid_ff || pop);
   assign in_fffd = job.has_fffd && (idx_ff < 3'd3);
   assign cp_idx  = job.has_fffd ? idx_ff - 3'd3 : idx_ff;

   // Length of the code point's encoding.
   always_comb begin
      if (job.cp < 21'h80) begin
         cp_len = 3'd1;
      end else if (job.cp < 21'h800) begin
         cp_len = 3'd2;
      end else if (job.cp < 21'h10000) begin
         cp_len = 3'd3;
      end else begin
         cp_len = 3'd4;
      end
   end

   // Select the byte of the code point at the current position.
   always_comb begin
      cp_byte = {2'b10, job.cp[5:0]};
      case (cp_len)
         3'd1: cp_byte = {1'b0, job.cp[6:0]};
         3'd2: begin
            if (cp_idx == 3'd0) cp_byte = {3'b110, job.cp[10:6]};
         end
         3'd3: begin
            if (cp_idx == 3'd0)      cp_byte = {4'b1110, job.cp[15:12]};
            else if (cp_idx == 3'd1) cp_byte = {2'b10, job.cp[11:6]};
         end
         default: begin
            if (cp_idx == 3'd0)      cp_byte = {5'b11110, job.cp[20:18]};
            else if (cp_idx == 3'd1) cp_byte = {2'b10, job.cp[17:12]};
            else if (cp_idx == 3'd2) cp_byte = {2'b10, job.cp[11:6]};
         end
      endcase
   end

   // The replacement character is always EF BF BD.
   always_comb begin
      case (idx_ff[1:0])
         2'd0:    fffd_byte = 8'hEF;
         2'd1:    fffd_byte = 8'hBF;
         default: fffd_byte = 8'hBD;
      endcase
   end

   // Sequence the bytes of the head job into the output register.
   always_comb begin
      idx_in   = idx_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !pop;
      q_pop    = 1'b0;
      if (advance) begin
         valid_in = 1'b1;
         if (in_fffd) begin
            byte_in = fffd_byte;
            last_in = (idx_ff == 3'd2) && !job.has_cp;
         end else begin
            byte_in = cp_byte;
            last_in = (cp_idx == cp_len - 3'd1);
         end
         if (last_in) begin
            idx_in = 3'd0;
            q_pop  = 1'b1;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   assign b_status.job_done = q_pop;
   assign empty     = !valid_ff;
   assign out_byte  = byte_ff;
   assign last_byte = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // Output word payload.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule
`default_nettype wire

[src/utf16_to_utf8_with_dedupe.sv]
// Top level of the UTF-16 to UTF-8 transcoder with repeat suppression.
//
//   channel   ports                                     direction
//   request   push full req_code_unit req_time_ms       in  (one UTF-16 word)
//   response  empty pop rsp_out_byte rsp_last_byte      out (one UTF-8 byte per transfer)
//   csr       valid ready csr_dedupe_window_ms          in  (repeat window, ms)
//
// A word is accepted in any cycle in which the job queue has room; the front
// classifies it in that same cycle. When the back is idle, the first byte of a word
// is registered in the job queue and then in the output register; the back then
// emits one byte per cycle while pop is held, up to six for a word, the byte count of
// its encoding; a dropped word or a held high surrogate never reaches the back. Reset
// clears the held surrogate, the repeat history and the queue, and loads a 60 ms
// window. A stalled output holds the back, which fills the queue and then raises full.
`timescale 1ns / 1ps
`default_nettype none
`include "utf16_to_utf8_with_dedupe_macros.svh"
module utf16_to_utf8_with_dedupe
   import u2u_pkg::*;
#(
   parameter int QUEUE_DEPTH = JOB_QUEUE_DEPTH
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [15:0] req_code_unit,
   input  wire logic [31:0] req_time_ms,
   output logic             empty,
   input  wire logic        pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last_byte,
   input  wire logic        valid,
   output logic             ready,
   input  wire logic [15:0] csr_dedupe_window_ms
);

   logic [15:0]      window_ff;
   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;
   back_status_type  b_status;

   // Repeat window register.
   assign ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (valid && ready) begin
         window_ff <= csr_dedupe_window_ms;
      end
   end

   u2u_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .code_unit (req_code_unit),
      .time_ms   (req_time_ms),
      .window_ms (window_ff),
      .q_status  (q_status),
      .full      (full),
      .q_push    (q_push),
      .q_job     (push_job)
   );

   u2u_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   u2u_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (head_job),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .b_status  (b_status),
      .pop       (pop),
      .empty     (empty),
      .out_byte  (rsp_out_byte),
      .last_byte (rsp_last_byte)
   );

   // Retiring a job always leaves its final byte in the output register.
   `U2U_ASSERT_NEXT(a_done_last, clock, reset, b_status.job_done, !empty && rsp_last_byte)
   // A full queue stays full until the back retires a job.
   `U2U_ASSERT_NEXT(a_full_holds, clock, reset, full && !q_pop, full)
   // The back only retires a job when the queue holds one.
   `U2U_ASSERT_SAME(a_pop_nonempty, clock, reset, q_pop, !q_status.empty)

endmodule
`default_nettype wire

[verif/utf8_byte_checker.sv]
// Watches the transcoder's channels, predicts its UTF-8 bytes and compares them.
`timescale 1ns / 1ps
module utf8_byte_checker
   import u2u_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic [15:0] req_code_unit,
   input  wire logic [31:0] req_time_ms,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [7:0]  rsp_out_byte,
   input  wire logic        rsp_last_byte,
   input  wire logic        valid,
   input  wire logic        ready,
   input  wire logic [15:0] csr_dedupe_window_ms,
   output int               mismatch_count,
   output int               bytes_pending
);

   // UTF-8 lead and continuation markers.
   localparam logic [7:0] LEAD_TWO   = 8'hC0;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;
   localparam logic [7:0] CONT_MARK  = 8'h80;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } utf8_byte_type;

   // Predicted state of the block.
   logic [15:0]   window_ms;
   logic [15:0]   held_high;
   logic [15:0]   last_unit;
   logic [31:0]   last_stamp;
   utf8_byte_type expected_bytes[$];

   int mismatches = 0;
   int pending    = 0;

   assign mismatch_count = mismatches;
   assign bytes_pending  = pending;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Appends the UTF-8 encoding of one code point to the expected bytes.
   function automatic void queue_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         expected_bytes.push_back('{data: cp[7:0], is_last: 1'b0});
      end else if (cp < 21'h800) begin
         expected_bytes.push_back('{data: LEAD_TWO | {3'd0, cp[10:6]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[5:0]}, is_last: 1'b0});
      end else if (cp < PLANE_BASE) begin
         expected_bytes.push_back('{data: LEAD_THREE | {4'd0, cp[15:12]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[11:6]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[5:0]}, is_last: 1'b0});
      end else begin
         expected_bytes.push_back('{data: LEAD_FOUR | {5'd0, cp[20:18]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[17:12]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[11:6]}, is_last: 1'b0});
         expected_bytes.push_back('{data: CONT_MARK | {2'd0, cp[5:0]}, is_last: 1'b0});
      end
   endfunction

   // Works out the bytes that one accepted word causes.
   task automatic predict_word(input logic [15:0] unit, input logic [31:0] stamp);
      int            size_at_start;
      logic          unit_is_low;
      utf8_byte_type tail;
      size_at_start = expected_bytes.size();
      unit_is_low   = (unit >= LOW_FIRST) && (unit <= LOW_LAST);

      // A repeat inside the window is dropped without touching any state.
      if (unit == last_unit) begin
         if ((stamp - last_stamp) < {16'd0, window_ms}) return;
         last_stamp = stamp;
      end else begin
         last_unit  = unit;
         last_stamp = stamp;
      end

      if (held_high != 16'd0 && unit_is_low) begin
         // A held high surrogate and a low one make a supplementary code point.
         queue_code_point(PLANE_BASE + {1'b0, held_high[9:0], unit[9:0]});
         held_high = 16'd0;
      end else begin
         // An orphan high surrogate is replaced before the new word is handled.
         if (held_high != 16'd0) begin
            queue_code_point(REPLACEMENT);
            held_high = 16'd0;
         end
         if (unit >= HIGH_FIRST && unit <= HIGH_LAST) begin
            held_high = unit;
         end else if (unit_is_low) begin
            queue_code_point(REPLACEMENT);
         end else begin
            queue_code_point({5'd0, unit});
         end
      end

      // Flag the final byte of this word.
      if (expected_bytes.size() > size_at_start) begin
         tail = expected_bytes.pop_back();
         tail.is_last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      utf8_byte_type want;
      if (reset) begin
         window_ms  = WINDOW_RESET;
         held_high  = 16'd0;
         last_unit  = 16'd0;
         last_stamp = 32'd0;
         expected_bytes.delete();
      end else begin
         // Outgoing byte first, so a byte can never match a word taken at the same edge.
         if (pop && !empty) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %h last %b",
                                         rsp_out_byte, rsp_last_byte));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch($sformatf("out_byte %h, expected %h",
                                            rsp_out_byte, want.data));
               if (rsp_last_byte !== want.is_last)
                  report_mismatch($sformatf("last_byte %b, expected %b (byte %h)",
                                            rsp_last_byte, want.is_last, want.data));
            end
         end
         if (valid && ready) window_ms = csr_dedupe_window_ms;
         if (push && !full) predict_word(req_code_unit, req_time_ms);
      end
      pending = expected_bytes.size();
   end

endmodule

[verif/utf16_to_utf8_with_dedupe_tb.sv]
// Stimulus and verdict for the UTF-16 to UTF-8 transcoder with repeat suppression.
`timescale 1ns / 1ps
module utf16_to_utf8_with_dedupe_tb
   import u2u_pkg::*;
();

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES    = 8;
   localparam int DIRECTED_COUNT   = 25;

   logic        clock                = 1'b0;
   logic        reset                = 1'b1;
   logic        push                 = 1'b0;
   logic [15:0] req_code_unit        = 16'd0;
   logic [31:0] req_time_ms          = 32'd0;
   logic        pop                  = 1'b0;
   logic        valid                = 1'b0;
   logic [15:0] csr_dedupe_window_ms = 16'd0;
   wire logic   full;
   wire logic   empty;
   wire logic   ready;
   wire logic [7:0] rsp_out_byte;
   wire logic   rsp_last_byte;
   int          mismatch_count;
   int          bytes_pending;

   // Sender bookkeeping, used to build repeats around the window edge.
   logic [15:0] last_unit_sent = 16'd0;
   logic [31:0] clock_ms       = 32'd0;
   logic [31:0] window_now     = 32'd60;
   int          quiet_items    = 0;
   int          cycle_count    = 0;
   bit          long_hold_wanted = 1'b0;
   bit          long_hold_done   = 1'b0;

   // Directed words: a repeat of zero after reset, window edges, every encoding
   // length, surrogate pairs at both ends, lone and orphan surrogates, time wrap.
   logic [15:0] directed_units [DIRECTED_COUNT] = '{
      16'h0000, 16'h0041, 16'h0041, 16'h0041, 16'h007F, 16'h0080, 16'h07FF,
      16'h0800, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF, 16'hDC80,
      16'hD83D, 16'h0042, 16'hD800, 16'hDBFF, 16'hDE00, 16'hD801, 16'h00E9,
      16'hD801, 16'h20AC, 16'h0043, 16'h0043};
   logic [31:0] directed_stamps [DIRECTED_COUNT] = '{
      32'd5, 32'd100, 32'd120, 32'd160, 32'd300, 32'd400, 32'd500,
      32'd600, 32'd700, 32'd800, 32'd900, 32'd1000, 32'd1100, 32'd1200,
      32'd1300, 32'd1400, 32'd1500, 32'd1600, 32'd1700, 32'd1800, 32'd1900,
      32'd2000, 32'd2100, 32'hFFFF_FFF0, 32'h0000_0010};

   utf16_to_utf8_with_dedupe uut (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_code_unit        (req_code_unit),
      .req_time_ms          (req_time_ms),
      .empty                (empty),
      .pop                  (pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_byte        (rsp_last_byte),
      .valid                (valid),
      .ready                (ready),
      .csr_dedupe_window_ms (csr_dedupe_window_ms)
   );

   utf8_byte_checker check_bytes (
      .clock                (clock),
      .reset                (reset),
      .push                 (push),
      .full                 (full),
      .req_code_unit        (req_code_unit),
      .req_time_ms          (req_time_ms),
      .empty                (empty),
      .pop                  (pop),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last_byte        (rsp_last_byte),
      .valid                (valid),
      .ready                (ready),
      .csr_dedupe_window_ms (csr_dedupe_window_ms),
      .mismatch_count       (mismatch_count),
      .bytes_pending        (bytes_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[utf16_to_utf8_with_dedupe] ERROR");
         $finish;
      end
   end

   // Byte receiver: short and long stalls, busy stretches and one long hold-off.
   initial begin
      int pick;
      forever begin
         @(posedge clock);
         pick = $urandom_range(0, 99);
         if (long_hold_wanted && !long_hold_done) begin
            pop <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (pick < 20) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (pick < 24) begin
            pop <= 1'b0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else if (pick < 30) begin
            pop <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // Offers one word and waits until it is taken, then idles at random.
   task automatic send_unit(input logic [15:0] unit, input logic [31:0] stamp);
      int pick;
      int gap;
      push          <= 1'b1;
      req_code_unit <= unit;
      req_time_ms   <= stamp;
      do @(posedge clock); while (full);
      last_unit_sent = unit;
      clock_ms       = stamp;
      pick = $urandom_range(0, 99);
      gap  = 0;
      if (quiet_items > 0) quiet_items--;
      else if (pick < 4) quiet_items = $urandom_range(15, 50);
      else if (pick < 34) gap = $urandom_range(1, 3);
      else if (pick < 40) gap = $urandom_range(8, 40);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lets every expected byte come out, then lets a held or dropped word settle.
   task automatic wait_drained();
      push <= 1'b0;
      do @(negedge clock); while (bytes_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [15:0] window);
      valid                <= 1'b1;
      csr_dedupe_window_ms <= window;
      do @(posedge clock); while (!ready);
      valid      <= 1'b0;
      window_now = {16'd0, window};
   endtask

   // A word that is not a surrogate, spread over the three BMP byte lengths.
   function automatic logic [15:0] plain_unit();
      case ($urandom_range(0, 3))
         0:       return 16'($urandom_range(16'h0000, 16'h007F));
         1:       return 16'($urandom_range(16'h0080, 16'h07FF));
         2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
         default: return 16'($urandom_range(16'hE000, 16'hFFFF));
      endcase
   endfunction

   // Next arrival time: mostly close, sometimes far, now and then anywhere.
   function automatic logic [31:0] advance_stamp();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return clock_ms + $urandom_range(1, 200);
      else if (pick < 90) return clock_ms + $urandom_range(200, 70000);
      else return $urandom;
   endfunction

   // Mostly well-formed text with random content, plus repeats and noise.
   task automatic random_phase(input int quota);
      int          made;
      int          kind;
      logic [15:0] high;
      logic [31:0] gap_ms;
      made = 0;
      while (made < quota) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            send_unit(plain_unit(), advance_stamp());
            made++;
         end else if (kind < 55) begin
            high = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
            send_unit(high, advance_stamp());
            send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), advance_stamp());
            made += 2;
         end else if (kind < 65) begin
            // Repeat of the previous word around the window edge.
            case ($urandom_range(0, 4))
               0:       gap_ms = 32'd0;
               1:       gap_ms = window_now - 32'd1;
               2:       gap_ms = window_now;
               3:       gap_ms = window_now + 32'd1;
               default: gap_ms = $urandom_range(0, 2 * window_now + 1);
            endcase
            send_unit(last_unit_sent, clock_ms + gap_ms);
         end else if (kind < 73) begin
            send_unit(16'($urandom_range(LOW_FIRST, LOW_LAST)), advance_stamp());
            made++;
         end else if (kind < 83) begin
            // Orphan high surrogate followed by a plain word, another high or itself.
            high = 16'($urandom_range(HIGH_FIRST, HIGH_LAST));
            send_unit(high, advance_stamp());
            case ($urandom_range(0, 2))
               0:       send_unit(plain_unit(), advance_stamp());
               1:       send_unit(16'($urandom_range(HIGH_FIRST, HIGH_LAST)), advance_stamp());
               default: send_unit(high, advance_stamp());
            endcase
            made += 2;
         end else begin
            send_unit(16'($urandom), $urandom);
            made++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words under the reset window.
      for (int i = 0; i < DIRECTED_COUNT; i++) send_unit(directed_units[i], directed_stamps[i]);
      wait_drained();

      // Window disabled, with the receiver holding off long enough to fill the block.
      write_window(16'd0);
      long_hold_wanted = 1'b1;
      random_phase(45);
      wait_drained();

      write_window(16'hFFFF);
      random_phase(45);
      wait_drained();

      write_window(16'd1);
      random_phase(45);
      wait_drained();

      write_window(16'($urandom_range(2, 500)));
      random_phase(50);
      wait_drained();

      write_window(16'($urandom));
      random_phase(45);
      wait_drained();

      write_window(WINDOW_RESET);
      random_phase(45);
      wait_drained();

      repeat (20) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[utf16_to_utf8_with_dedupe] OK");
      end else begin
         $display("[utf16_to_utf8_with_dedupe] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/u2u_pkg.sv
src/u2u_front.sv
src/u2u_queue.sv
src/u2u_back.sv
src/utf16_to_utf8_with_dedupe.sv
verif/utf8_byte_checker.sv
verif/utf16_to_utf8_with_dedupe_tb.sv
